@@ hw/rtl/led_driver_chain_serializer_macros.svh @@
// ----------------------------------------------------------------------------
// led driver chain serializer assertion macros
// concurrent checks clocked on clk_i, held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef LED_DRIVER_CHAIN_SERIALIZER_MACROS_SVH
`define LED_DRIVER_CHAIN_SERIALIZER_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every edge out of reset
`define LDCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ldcs assertion failed");
// consequent must hold in the cycle after the antecedent
`define LDCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ldcs assertion failed");
`else
`define LDCS_ASSERT(lbl, prop)
`define LDCS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/ldcs_pkg.sv @@
// ----------------------------------------------------------------------------
// ldcs_pkg
// shared types and constants of the led driver chain serializer
// ----------------------------------------------------------------------------
package ldcs_pkg;

  localparam int MAX_DRIVERS = 64;
  localparam int NUM_DRV_W   = 7;
  localparam int DRV_W       = $clog2(MAX_DRIVERS);
  localparam int CHAN_W      = 4;
  localparam int WORD_W      = 16;
  localparam int BRIGHT_W    = 6;
  localparam int SYM_CNT_W   = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DRIVERS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 1'd1;

  localparam logic [NUM_DRV_W-1:0] NUM_DRV_RESET = 7'd1;
  localparam logic [BRIGHT_W-1:0]  BRIGHT_RESET  = 6'd63;

  localparam logic [CHAN_W-1:0]    CHAN_TOP   = 4'd15;
  localparam logic [SYM_CNT_W-1:0] SYM_LAST   = 4'd15;

  localparam logic [WORD_W-1:0] LATCH_PIXEL  = 16'h000F;
  localparam logic [WORD_W-1:0] LATCH_GLOBAL = 16'h003F;
  localparam logic [WORD_W-1:0] LATCH_CONFIG = 16'h007F;
  localparam logic [WORD_W-1:0] LATCH_ENABLE = 16'h0003;
  localparam logic [WORD_W-1:0] CFG_FIXED    = 16'h20C0;
  localparam logic [WORD_W-1:0] ENABLE_WORD  = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_CONFIG = 2'd1,
    KIND_ENABLE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // one queued word with its latch mask and sequence end flag
  typedef struct packed {
    logic              ends;
    logic [WORD_W-1:0] latch;
    logic [WORD_W-1:0] word;
  } sym_word_t;

endpackage

@@ hw/rtl/ldcs_front.sv @@
// ----------------------------------------------------------------------------
// ldcs_front
// takes input words, tracks frame position, builds word and latch mask
// ----------------------------------------------------------------------------
module ldcs_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         cmd_i,
  input  logic [ldcs_pkg::WORD_W-1:0]        pixel_i,
  input  logic [ldcs_pkg::NUM_DRV_W-1:0]     num_drivers_i,
  input  logic [ldcs_pkg::BRIGHT_W-1:0]      brightness_i,
  input  logic                               q_ready_i,
  output logic                               push_o,
  output ldcs_pkg::sym_word_t                entry_o
);
  import ldcs_pkg::*;

  kind_e              kind_q, kind_d, cmd_kind;
  logic [DRV_W-1:0]   drv_q, drv_d, drv_cur, drv_last;
  logic [CHAN_W-1:0]  chan_q, chan_d, chan_cur;
  logic               accept, restart, ends;
  logic [WORD_W-1:0]  word, latch;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign cmd_kind   = kind_e'(cmd_i);

  // clamped driver count minus one
  always_comb begin
    if (num_drivers_i == '0) begin
      drv_last = '0;
    end else if (num_drivers_i > NUM_DRV_W'(MAX_DRIVERS)) begin
      drv_last = DRV_W'(MAX_DRIVERS - 1);
    end else begin
      drv_last = DRV_W'(num_drivers_i - NUM_DRV_W'(1));
    end
  end

  assign restart  = (cmd_kind != kind_q);
  assign drv_cur  = restart ? drv_last : drv_q;
  assign chan_cur = restart ? CHAN_TOP : chan_q;

  always_comb begin
    word  = ENABLE_WORD;
    latch = '0;
    ends  = (drv_cur == '0);
    case (cmd_kind)
      KIND_PIXEL: begin
        word = pixel_i;
        if (drv_cur == '0) begin
          latch = (chan_cur == '0) ? LATCH_GLOBAL : LATCH_PIXEL;
        end
        ends = (drv_cur == '0) && (chan_cur == '0);
      end
      KIND_CONFIG: begin
        word = CFG_FIXED | WORD_W'(brightness_i);
        if (drv_cur == '0) begin
          latch = LATCH_CONFIG;
        end
      end
      KIND_ENABLE: begin
        if (drv_cur == '0) begin
          latch = LATCH_ENABLE;
        end
      end
      default: begin
        word  = ENABLE_WORD;
        latch = '0;
        ends  = 1'b0;
      end
    endcase
  end

  assign push_o        = accept && (cmd_kind != KIND_NONE);
  assign entry_o.word  = word;
  assign entry_o.latch = latch;
  assign entry_o.ends  = ends;

  always_comb begin
    kind_d = kind_q;
    drv_d  = drv_q;
    chan_d = chan_q;
    if (push_o) begin
      if (ends) begin
        kind_d = KIND_NONE;
        drv_d  = '0;
        chan_d = CHAN_TOP;
      end else if (drv_cur != '0) begin
        kind_d = cmd_kind;
        drv_d  = drv_cur - DRV_W'(1);
        chan_d = chan_cur;
      end else begin
        // driver 0 of a pixel channel done, step to next channel
        kind_d = cmd_kind;
        drv_d  = drv_last;
        chan_d = chan_cur - CHAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_NONE;
      drv_q  <= '0;
      chan_q <= CHAN_TOP;
    end else begin
      kind_q <= kind_d;
      drv_q  <= drv_d;
      chan_q <= chan_d;
    end
  end

endmodule

@@ hw/rtl/ldcs_queue.sv @@
// ----------------------------------------------------------------------------
// ldcs_queue
// two-entry fifo between word builder and shifter
// ----------------------------------------------------------------------------
module ldcs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ldcs_pkg::sym_word_t entry_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                pop_i,
  output ldcs_pkg::sym_word_t entry_o
);
  import ldcs_pkg::*;

  sym_word_t            slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign ready_o = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + Q_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/ldcs_shifter.sv @@
// ----------------------------------------------------------------------------
// ldcs_shifter
// shifts one queued word out as sixteen registered symbols, msb first
// ----------------------------------------------------------------------------
module ldcs_shifter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  ldcs_pkg::sym_word_t q_entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                data_bit_o,
  output logic                latch_bit_o,
  output logic                word_last_o,
  output logic                sequence_last_o
);
  import ldcs_pkg::*;

  logic                   busy_q, busy_d;
  logic [SYM_CNT_W-1:0]   cnt_q, cnt_d;
  logic [WORD_W-1:0]      word_q, word_d, latch_q, latch_d;
  logic                   ends_q, ends_d;
  logic                   out_hs, last_sym, load;

  assign out_valid_o     = busy_q;
  assign data_bit_o      = word_q[WORD_W-1];
  assign latch_bit_o     = latch_q[WORD_W-1];
  assign last_sym        = (cnt_q == SYM_LAST);
  assign word_last_o     = last_sym;
  assign sequence_last_o = last_sym & ends_q;

  assign out_hs = busy_q & out_ready_i;
  assign load   = q_valid_i & (!busy_q | (out_hs & last_sym));
  assign pop_o  = load;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    latch_d = latch_q;
    ends_d  = ends_q;
    if (load) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      word_d  = q_entry_i.word;
      latch_d = q_entry_i.latch;
      ends_d  = q_entry_i.ends;
    end else if (out_hs) begin
      if (last_sym) begin
        busy_d = 1'b0;
      end else begin
        cnt_d   = cnt_q + SYM_CNT_W'(1);
        word_d  = {word_q[WORD_W-2:0], 1'b0};
        latch_d = {latch_q[WORD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    latch_q <= latch_d;
    ends_q  <= ends_d;
  end

endmodule

@@ hw/rtl/led_driver_chain_serializer.sv @@
// ----------------------------------------------------------------------------
// led_driver_chain_serializer
// turns 16-bit words into data/latch symbols for a chain of led drivers
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                                  request
//  s_axis    in    tuser: cmd, tdata: pixel_value           one 16-bit word
//  m_axis    out   tdata: data/latch/word_last, tlast: seq  one serial symbol
//  cfg       in    cfg_index_i, cfg_data_i                  one register write
//
//  each word gives 16 symbols, one per cycle while m_axis is ready, so the
//  sustained word rate is set by the single shifter
//  a two-entry queue lets the input take two more words while one shifts out
//  reset clears the position (no kind, driver 0, channel 15), the queue and
//  the shifter; num_drivers resets to 1 and brightness to 63
//  a stalled output holds the current symbol; cmd 3 is taken and dropped
//
`include "led_driver_chain_serializer_macros.svh"

module led_driver_chain_serializer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // [15:0] pixel_value
  input  logic [1:0]                          s_axis_tuser,  // [1:0] cmd
  // serial symbols
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] data_bit, [1] latch_bit, [2] word_last, [7:3] zero
  output logic [7:0]                          m_axis_tdata,
  output logic                                m_axis_tlast,  // sequence_last
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ldcs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ldcs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ldcs_pkg::*;

  // configuration registers
  logic [NUM_DRV_W-1:0] num_drivers_q;
  logic [BRIGHT_W-1:0]  brightness_q;
  logic                 cfg_hs;

  // front to queue
  logic       push, q_ready;
  sym_word_t  front_entry;

  // queue to shifter
  logic       q_valid, pop;
  sym_word_t  q_entry;

  // shifter outputs
  logic       data_bit, latch_bit, word_last, sequence_last;

  // registers always writable; user writes only while idle, not enforced here
  assign cfg_ready_o = 1'b1;
  assign cfg_hs      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_drivers_q <= NUM_DRV_RESET;
      brightness_q  <= BRIGHT_RESET;
    end else if (cfg_hs) begin
      case (cfg_index_i)
        REG_NUM_DRIVERS: num_drivers_q <= cfg_data_i;
        REG_BRIGHTNESS:  brightness_q  <= cfg_data_i[BRIGHT_W-1:0];
        default: begin
          num_drivers_q <= num_drivers_q;
        end
      endcase
    end
  end

  // word builder: position tracking, latch mask and sequence end
  ldcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .cmd_i         (s_axis_tuser),
    .pixel_i       (s_axis_tdata),
    .num_drivers_i (num_drivers_q),
    .brightness_i  (brightness_q),
    .q_ready_i     (q_ready),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  // decoupling queue
  ldcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (q_entry)
  );

  // serial back end, symbols leave straight from its registers
  ldcs_shifter u_shifter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .data_bit_o      (data_bit),
    .latch_bit_o     (latch_bit),
    .word_last_o     (word_last),
    .sequence_last_o (sequence_last)
  );

  assign m_axis_tdata = {5'd0, word_last, latch_bit, data_bit};
  assign m_axis_tlast = sequence_last;

  // a sequence only ends on the last symbol of a word
  `LDCS_ASSERT(a_seq_last_on_word_last, !m_axis_tvalid || !m_axis_tlast || m_axis_tdata[2])

  // a queued word follows the previous word with no gap
  `LDCS_ASSERT_NEXT(a_no_gap_between_words,
                    m_axis_tvalid && m_axis_tready && word_last && q_valid, m_axis_tvalid)

  // brightness changes only through a register write
  `LDCS_ASSERT_NEXT(a_brightness_held,
                    !(cfg_hs && (cfg_index_i == REG_BRIGHTNESS)), $stable(brightness_q))

endmodule

@@ tb/led_driver_chain_serializer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_driver_chain_serializer_test
// streams pixel, config and enable words into the serializer and checks every
// serial symbol against a cycle-free model of the chain sequencing, across
// several driver counts and brightness settings, with random gaps and stalls
// ----------------------------------------------------------------------------
module led_driver_chain_serializer_test;
  import ldcs_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 24;     // queue plus shifter, with margin
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int PHASE_WORDS  = 8;      // counted words per phase with a short chain
  localparam int NUM_PHASES   = 9;
  localparam int HOLD_PHASE   = 3;
  localparam int CYCLE_LIMIT  = 400000;

  // one input request: cmd goes on tuser, pixel value on tdata
  typedef struct {
    kind_e       cmd;
    logic [15:0] pixel;
  } word_req_t;

  // one serial symbol as it appears on the output
  typedef struct packed {
    logic data_bit;
    logic latch_bit;
    logic word_last;
    logic seq_last;
  } symbol_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic        s_valid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_data  = '0;
  logic [1:0]  s_user  = '0;

  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // stimulus side
  word_req_t word_backlog[$];
  word_req_t cur_word = '{KIND_NONE, 16'h0000};
  logic      offer_word;
  int        burst_left = 0;
  int        gap_left   = 0;

  // predicted symbols, oldest first
  symbol_t due_symbols[$];
  symbol_t seen_want;

  // mirror of the register file and of the sequence position
  logic [NUM_DRV_W-1:0] drivers_reg = NUM_DRV_RESET;
  logic [BRIGHT_W-1:0]  bright_reg  = BRIGHT_RESET;
  kind_e                seq_kind    = KIND_NONE;
  logic [DRV_W-1:0]     drv_pos     = '0;
  logic [CHAN_W-1:0]    chan_pos    = CHAN_TOP;

  // receiver stall state
  rx_mode_e   rx_mode   = RX_STEADY;
  int         rx_left   = 0;
  logic [7:0] rx_mask   = 8'hFF;
  int         holds_asked = 0;
  int         holds_done  = 0;
  int         hold_count  = 0;

  // bookkeeping
  int mismatches      = 0;
  int words_taken     = 0;
  int words_ignored   = 0;
  int symbols_checked = 0;
  int sequence_ends   = 0;
  int reg_writes      = 0;
  int cycles          = 0;

  led_driver_chain_serializer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),         // [15:0] pixel_value
    .s_axis_tuser  (s_user),         // [1:0] cmd
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),   // [0] data_bit, [1] latch_bit, [2] word_last
    .m_axis_tlast  (m_axis_tlast),   // sequence_last
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // register value 0 behaves as one driver, anything past the maximum as the maximum
  function automatic int chain_length(input logic [NUM_DRV_W-1:0] setting);
    int n;
    n = int'(setting);
    if (n < 1) n = 1;
    if (n > MAX_DRIVERS) n = MAX_DRIVERS;
    return n;
  endfunction

  // works out the sixteen symbols of one accepted word and steps the position
  function automatic void serialize_word(input kind_e cmd, input logic [15:0] pixel);
    logic [15:0] word;
    logic [15:0] latch;
    logic        ends;
    int          n;
    symbol_t     sym;
    // unused selector: no symbols, position untouched
    if (cmd == KIND_NONE) return;
    n = chain_length(drivers_reg);
    // a different kind restarts at the far driver, top channel
    if (cmd != seq_kind) begin
      seq_kind = cmd;
      drv_pos  = DRV_W'(n - 1);
      chan_pos = CHAN_TOP;
    end
    latch = '0;
    case (cmd)
      KIND_PIXEL: begin
        word = pixel;
        // driver 0 latches the channel, channel 0 is the global latch
        if (drv_pos == 0) latch = (chan_pos == 0) ? LATCH_GLOBAL : LATCH_PIXEL;
        ends = (drv_pos == 0) && (chan_pos == 0);
      end
      KIND_CONFIG: begin
        word = CFG_FIXED | {{(WORD_W - BRIGHT_W){1'b0}}, bright_reg};
        if (drv_pos == 0) latch = LATCH_CONFIG;
        ends = (drv_pos == 0);
      end
      default: begin
        word = ENABLE_WORD;
        if (drv_pos == 0) latch = LATCH_ENABLE;
        ends = (drv_pos == 0);
      end
    endcase
    // msb first, one symbol per bit
    for (int k = 0; k < 16; k++) begin
      sym.data_bit  = word[15 - k];
      sym.latch_bit = latch[15 - k];
      sym.word_last = (k == 15);
      sym.seq_last  = (k == 15) && ends;
      due_symbols.push_back(sym);
    end
    if (ends) begin
      seq_kind = KIND_NONE;
      drv_pos  = '0;
      chan_pos = CHAN_TOP;
    end else if (drv_pos > 0) begin
      drv_pos = drv_pos - 1'b1;
    end else begin
      // frame: driver 0 done, next lower channel from the far driver
      drv_pos  = DRV_W'(n - 1);
      chan_pos = chan_pos - 1'b1;
    end
  endfunction

  function automatic void queue_word(input kind_e cmd, input logic [15:0] pixel);
    word_req_t req;
    req.cmd   = cmd;
    req.pixel = pixel;
    word_backlog.push_back(req);
  endfunction

  // pushes count words of one kind with random payload, noise words mixed in;
  // returns the number of words that produce symbols
  function automatic int queue_sequence(input kind_e cmd, input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 11) == 0) queue_word(KIND_NONE, 16'($urandom));
      queue_word(cmd, 16'($urandom));
    end
    return count;
  endfunction

  // whole frames and chain writes of up to 70 words in three of four draws, the rest cut short
  function automatic int sequence_length(input kind_e cmd, input int n);
    int whole;
    int cut;
    whole = (cmd == KIND_PIXEL) ? 16 * n : n;
    if (whole <= 70 && $urandom_range(0, 3) != 0) return whole;
    cut = (whole < n + 2) ? whole : n + 2;
    return $urandom_range(1, cut);
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == REG_NUM_DRIVERS) drivers_reg = val;
    else if (idx == REG_BRIGHTNESS) bright_reg = val[BRIGHT_W-1:0];
    reg_writes++;
  endtask

  // settle on the falling edge so no posedge ordering matters
  task automatic wait_idle();
    do @(negedge clk_i);
    while (word_backlog.size() != 0 || s_valid || due_symbols.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic check_bit(input string field, input logic want, input logic got);
    if (want !== got) begin
      $error("%s mismatch: expected %0b, actual %0b", field, want, got);
      mismatches++;
    end
  endtask

  // sender: bursts of requests with random gaps, predicts at acceptance
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (s_valid && s_axis_tready) begin
        if (cur_word.cmd == KIND_NONE) words_ignored++;
        else words_taken++;
        serialize_word(cur_word.cmd, cur_word.pixel);
      end
      // keep offering a request the block has not taken yet
      offer_word = s_valid && !s_axis_tready;
      if (!offer_word) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (word_backlog.size() > 0) begin
          cur_word   = word_backlog.pop_front();
          offer_word = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // now and then a long run with no gaps at all
            if ($urandom_range(0, 4) == 0) begin
              burst_left = $urandom_range(30, 60);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left   = $urandom_range(0, 20);
            end
          end
        end
      end
      s_valid <= offer_word;
      s_data  <= cur_word.pixel;
      s_user  <= cur_word.cmd;
    end
  end

  // receiver: own stall pattern, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (holds_done != holds_asked) begin
        m_ready <= 1'b0;
        if (hold_count == HOLD_CYCLES) begin
          holds_done++;
          hold_count = 0;
        end else begin
          hold_count++;
        end
      end else begin
        if (rx_left == 0) begin
          case ($urandom_range(0, 2))
            0:       rx_mode = RX_STEADY;
            1:       rx_mode = RX_RANDOM;
            default: rx_mode = RX_PATTERN;
          endcase
          rx_mask = 8'($urandom_range(1, 255)) | 8'h11;
          rx_left = $urandom_range(40, 200);
        end else begin
          rx_left--;
        end
        rx_mask = {rx_mask[6:0], rx_mask[7]};
        case (rx_mode)
          RX_STEADY:  m_ready <= 1'b1;
          RX_RANDOM:  m_ready <= ($urandom_range(0, 99) < 60);
          default:    m_ready <= rx_mask[0];
        endcase
      end
    end
  end

  // monitor: every accepted symbol against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid && m_ready) begin
      if (due_symbols.size() == 0) begin
        $error("unexpected symbol: tdata %h, tlast %b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        seen_want = due_symbols.pop_front();
        check_bit("data_bit", seen_want.data_bit, m_axis_tdata[0]);
        check_bit("latch_bit", seen_want.latch_bit, m_axis_tdata[1]);
        check_bit("word_last", seen_want.word_last, m_axis_tdata[2]);
        check_bit("sequence_last", seen_want.seq_last, m_axis_tlast);
        symbols_checked++;
        if (m_axis_tlast) sequence_ends++;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d symbols outstanding",
               cycles, due_symbols.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    logic [NUM_DRV_W-1:0] drv_settings[NUM_PHASES];
    logic [CFG_DATA_W-1:0] bright_val;
    logic [15:0] edge_pixels[8];
    kind_e last_kind;
    kind_e next_kind;
    int    counted;
    int    budget;
    int    len;
    int    n;

    // driver counts: low end, maximum, zero, past the maximum, random small
    drv_settings = '{7'd2, 7'd64, 7'd0, 7'd3, 7'd127, 7'd1, 7'd5,
                     7'($urandom_range(1, 4)), 7'd2};
    edge_pixels = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                    16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed, reset values: one driver, full brightness
    queue_word(KIND_ENABLE, 16'h1234);          // enable word, payload ignored
    queue_word(KIND_CONFIG, 16'hFFFF);          // config word from brightness
    queue_word(KIND_NONE, 16'hFFFF);            // unused selector, dropped
    // whole frame at one driver, channel 0 ends on the global latch
    for (int i = 0; i < 16; i++) begin
      queue_word(KIND_PIXEL, (i < 8) ? edge_pixels[i] : 16'($urandom));
      if (i == 8) queue_word(KIND_NONE, 16'h0000);  // mid-frame noise
    end
    queue_word(KIND_PIXEL, 16'hFFFF);           // frame started ...
    queue_word(KIND_PIXEL, 16'h0000);
    queue_word(KIND_ENABLE, 16'h0000);          // ... and broken by a kind change
    wait_idle();

    // random phases, each with its own register setting
    last_kind = KIND_PIXEL;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       bright_val = 7'd0;
        1:       bright_val = 7'h7F;             // bit 6 beyond the register
        default: bright_val = 7'($urandom);
      endcase
      write_register(REG_NUM_DRIVERS, drv_settings[p]);
      write_register(REG_BRIGHTNESS, bright_val);
      n = chain_length(drivers_reg);
      // a long chain gets room for one whole chain write
      budget = (n > PHASE_WORDS) ? n + 2 : PHASE_WORDS;
      // receiver goes quiet while requests keep coming
      if (p == HOLD_PHASE) holds_asked++;
      counted = 0;
      while (counted < budget) begin
        if (counted == 0 && n > PHASE_WORDS) begin
          // fresh chain write down to driver 0 of a long chain
          next_kind = (last_kind == KIND_CONFIG) ? KIND_ENABLE : KIND_CONFIG;
          len       = n;
        end else begin
          // half the time pick up the kind left open by the last phase,
          // so a new driver count meets a sequence in progress
          if (counted == 0 && $urandom_range(0, 1) == 1) begin
            next_kind = last_kind;
          end else begin
            case ($urandom_range(0, 3))
              0, 1:    next_kind = KIND_PIXEL;
              2:       next_kind = KIND_CONFIG;
              default: next_kind = KIND_ENABLE;
            endcase
          end
          len = sequence_length(next_kind, n);
        end
        if (len > budget - counted) len = budget - counted;
        counted += queue_sequence(next_kind, len);
        last_kind = next_kind;
      end
      wait_idle();
    end

    if (due_symbols.size() != 0) begin
      $error("%0d predicted symbols never arrived", due_symbols.size());
      mismatches++;
    end
    $display("covered %0d words and %0d dropped selectors over %0d register writes",
             words_taken, words_ignored, reg_writes);
    $display("checked %0d symbols, %0d sequence ends, %0d long receiver hold-offs",
             symbols_checked, sequence_ends, holds_done);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ led_driver_chain_serializer.f @@
+incdir+hw/rtl
hw/rtl/ldcs_pkg.sv
hw/rtl/ldcs_front.sv
hw/rtl/ldcs_queue.sv
hw/rtl/ldcs_shifter.sv
hw/rtl/led_driver_chain_serializer.sv
tb/led_driver_chain_serializer_test.sv
